>>> design/m3a_pkg.sv
package m3a_pkg;

    // request types
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_EXEC   = 2'd2;

    // operation codes
    localparam logic [2:0] OP_MUL    = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_SCALE  = 3'd3;
    localparam logic [2:0] OP_TRANSP = 3'd4;
    localparam logic [2:0] OP_INV    = 3'd5;

    localparam logic [3:0] LAST_ELEM = 4'd8;

    // accumulator operations of the shared unit
    typedef logic [2:0] t_acc_op;
    localparam t_acc_op ACC_NOP  = 3'd0;
    localparam t_acc_op ACC_SET  = 3'd1; // acc = round(prod)
    localparam t_acc_op ACC_ADD  = 3'd2; // acc += round(prod)
    localparam t_acc_op ACC_SUB  = 3'd3; // acc -= round(prod)
    localparam t_acc_op ACC_SUM  = 3'd4; // acc = x + y
    localparam t_acc_op ACC_DIFF = 3'd5; // acc = x - y

    typedef struct packed {
        logic    mul_en;
        t_acc_op acc_op;
    } t_mac_ctl;

    // operand element indices {x, y} for one term of one result element
    function automatic logic [7:0] f_opnd_idx(input logic [2:0] op, input logic [3:0] e,
                                              input logic [1:0] term);
        logic [3:0] rr;
        logic [3:0] cc;
        logic [3:0] tt;
        logic [3:0] ix;
        logic [3:0] iy;
        rr = (e >= 4'd6) ? 4'd2 : ((e >= 4'd3) ? 4'd1 : 4'd0);
        cc = e - 4'(rr * 4'd3);
        tt = {2'b00, term};
        ix = e;
        iy = e;
        case (op)
            OP_MUL: begin
                ix = 4'(rr * 4'd3) + tt;
                iy = 4'(tt * 4'd3) + cc;
            end
            OP_TRANSP: begin
                ix = 4'(cc * 4'd3) + rr;
            end
            OP_INV: begin
                // cofactor = a[ix0]*a[iy0] - a[ix1]*a[iy1]
                case (e)
                    4'd0: begin ix = term[0] ? 4'd7 : 4'd4; iy = term[0] ? 4'd5 : 4'd8; end
                    4'd1: begin ix = term[0] ? 4'd1 : 4'd2; iy = term[0] ? 4'd8 : 4'd7; end
                    4'd2: begin ix = term[0] ? 4'd2 : 4'd1; iy = term[0] ? 4'd4 : 4'd5; end
                    4'd3: begin ix = term[0] ? 4'd3 : 4'd5; iy = term[0] ? 4'd8 : 4'd6; end
                    4'd4: begin ix = term[0] ? 4'd2 : 4'd0; iy = term[0] ? 4'd6 : 4'd8; end
                    4'd5: begin ix = term[0] ? 4'd0 : 4'd3; iy = term[0] ? 4'd5 : 4'd2; end
                    4'd6: begin ix = term[0] ? 4'd6 : 4'd3; iy = term[0] ? 4'd4 : 4'd7; end
                    4'd7: begin ix = term[0] ? 4'd0 : 4'd6; iy = term[0] ? 4'd7 : 4'd1; end
                    default: begin ix = term[0] ? 4'd3 : 4'd0; iy = term[0] ? 4'd1 : 4'd4; end
                endcase
            end
            default: begin
                ix = e;
                iy = e;
            end
        endcase
        return {ix, iy};
    endfunction

endpackage

>>> design/m3a_if.sv
// request channel: loads and execute commands
interface m3a_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [3:0]         elem_index;
    logic signed [31:0] operand_value;
    logic [2:0]         op_code;

    modport source (output valid, req_type, elem_index, operand_value, op_code, input ready);
    modport sink   (input valid, req_type, elem_index, operand_value, op_code, output ready);
endinterface

// result channel: one element per word
interface m3a_res_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic               last_elem;
    logic               saturated;
    logic               div_zero;

    modport source (output valid, out_index, out_value, last_elem, saturated, div_zero,
                    input ready);
    modport sink   (input valid, out_index, out_value, last_elem, saturated, div_zero,
                    output ready);
endinterface

>>> design/m3a_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, rounding to
// Q16.16 and a 50-bit accumulator with saturation to 32 bits.
module m3a_mac (
    input  logic                i_clk,
    input  m3a_pkg::t_mac_ctl   i_ctl,
    input  logic signed [31:0]  i_x,
    input  logic signed [31:0]  i_y,
    output logic signed [49:0]  o_acc,
    output logic signed [31:0]  o_sat_val,
    output logic                o_sat
);

    logic signed [63:0] r_prod;
    logic signed [49:0] r_acc;
    logic signed [49:0] n_acc;
    logic signed [63:0] w_round;
    logic signed [49:0] w_rnd;
    logic signed [49:0] w_xe;
    logic signed [49:0] w_ye;

    // round to nearest, ties up: floor((p + 2^15) / 2^16)
    assign w_round = (r_prod + 64'sd32768) >>> 16;
    assign w_rnd   = w_round[49:0];
    assign w_xe    = {{18{i_x[31]}}, i_x};
    assign w_ye    = {{18{i_y[31]}}, i_y};

    always_comb begin
        n_acc = r_acc;
        case (i_ctl.acc_op)
            m3a_pkg::ACC_SET:  n_acc = w_rnd;
            m3a_pkg::ACC_ADD:  n_acc = r_acc + w_rnd;
            m3a_pkg::ACC_SUB:  n_acc = r_acc - w_rnd;
            m3a_pkg::ACC_SUM:  n_acc = w_xe + w_ye;
            m3a_pkg::ACC_DIFF: n_acc = w_xe - w_ye;
            default:           n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= 64'(i_x) * 64'(i_y);
        end
        r_acc <= n_acc;
    end

    // clip to int32
    always_comb begin
        o_sat     = 1'b0;
        o_sat_val = r_acc[31:0];
        if (r_acc > 50'sd2147483647) begin
            o_sat     = 1'b1;
            o_sat_val = 32'sh7FFF_FFFF;
        end else if (r_acc < -50'sd2147483648) begin
            o_sat     = 1'b1;
            o_sat_val = 32'sh8000_0000;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> design/m3a_div.sv
// Radix-2 restoring divider: (cof * 2^16) / det, truncated toward zero and
// saturated. Overflow is caught up front, otherwise 32 steps of one bit.
module m3a_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [49:0] i_cof,
    input  logic signed [31:0] i_det,
    output logic               o_done,
    output logic signed [31:0] o_q,
    output logic               o_sat
);

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic               r_neg;
    logic [31:0]        r_den;
    logic [31:0]        r_rem;
    logic [31:0]        r_quo;
    logic signed [31:0] r_q;
    logic               r_sat;

    logic [49:0] w_cmag;
    logic [31:0] w_dmag;
    logic [63:0] w_num;
    logic        w_ovf;
    logic [32:0] w_rem2;
    logic        w_ge;
    logic [32:0] w_diff;
    logic [31:0] w_rem_n;
    logic [31:0] w_quo_n;
    logic [31:0] w_fin_q;
    logic        w_fin_sat;

    // operand magnitudes
    assign w_cmag = i_cof[49] ? 50'(-i_cof) : 50'(i_cof);
    assign w_dmag = i_det[31] ? 32'(-i_det) : 32'(i_det);
    assign w_num  = {w_cmag[47:0], 16'h0000};
    assign w_ovf  = (w_num[63:32] >= w_dmag);

    // one quotient bit
    assign w_rem2  = {r_rem, r_quo[31]};
    assign w_ge    = (w_rem2 >= {1'b0, r_den});
    assign w_diff  = w_rem2 - {1'b0, r_den};
    assign w_rem_n = w_ge ? w_diff[31:0] : w_rem2[31:0];
    assign w_quo_n = {r_quo[30:0], w_ge};

    // sign and clip
    always_comb begin
        w_fin_sat = 1'b0;
        w_fin_q   = w_quo_n;
        if (r_neg) begin
            if (w_quo_n > 32'h8000_0000) begin
                w_fin_sat = 1'b1;
                w_fin_q   = 32'h8000_0000;
            end else begin
                w_fin_q = 32'(-w_quo_n);
            end
        end else if (w_quo_n[31]) begin
            w_fin_sat = 1'b1;
            w_fin_q   = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= i_cof[49] ^ i_det[31];
                if (w_ovf) begin
                    r_done <= 1'b1;
                    r_sat  <= 1'b1;
                    r_q    <= (i_cof[49] ^ i_det[31]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 5'd0;
                    r_den  <= w_dmag;
                    r_rem  <= w_num[63:32];
                    r_quo  <= w_num[31:0];
                end
            end else if (r_busy) begin
                r_rem <= w_rem_n;
                r_quo <= w_quo_n;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= w_fin_q;
                    r_sat  <= w_fin_sat;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_sat  = r_sat;

endmodule

>>> design/matrix3x3_alu.sv
// Execute: 9 elements in turn, then a write-back state, then 9 result words.
// Per element states: add/sub/transpose MUL, FIN; scale MUL, ACC, FIN; multiply
// MUL, ACC per term, then FIN; inverse two products, FIN and a bit-serial divide.
// One item at a time; the next request is taken once the last word is queued.
// i_rst_n is synchronous, active low; it clears both matrices and the control.
module matrix3x3_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    m3a_req_if.sink     i_req_ch,
    m3a_res_if.source   o_res_ch
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_WB   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]         r_state;
    logic [3:0]         r_elem;
    logic [1:0]         r_term;
    logic [2:0]         r_op;
    logic signed [31:0] r_val;
    logic               r_dz;
    logic [3:0]         r_oidx;
    logic signed [31:0] r_a [9];
    logic signed [31:0] r_b [9];
    logic signed [31:0] r_res [9];
    logic               r_sat [9];

    logic               r_ovalid;
    logic [3:0]         r_oindex;
    logic signed [31:0] r_ovalue;
    logic               r_olast;
    logic               r_osat;
    logic               r_odz;

    m3a_pkg::t_mac_ctl  w_ctl;
    logic [7:0]         w_idx;
    logic signed [31:0] w_x;
    logic signed [31:0] w_y;
    logic signed [49:0] w_acc;
    logic signed [31:0] w_sat_val;
    logic               w_sat;
    logic               w_div_start;
    logic               w_div_done;
    logic signed [31:0] w_div_q;
    logic               w_div_sat;
    logic [1:0]         w_last_term;
    logic               w_direct;
    logic               w_req_acc;
    logic               w_out_load;

    assign i_req_ch.ready = (r_state == ST_IDLE);
    assign w_req_acc      = i_req_ch.valid && (r_state == ST_IDLE);
    assign w_out_load     = (r_state == ST_OUT) && (!r_ovalid || o_res_ch.ready);

    assign w_direct    = (r_op == m3a_pkg::OP_ADD) || (r_op == m3a_pkg::OP_SUB) ||
                         (r_op == m3a_pkg::OP_TRANSP);
    assign w_last_term = (r_op == m3a_pkg::OP_MUL) ? 2'd2 :
                         ((r_op == m3a_pkg::OP_INV) ? 2'd1 : 2'd0);

    // operand selection
    assign w_idx = m3a_pkg::f_opnd_idx(r_op, r_elem, r_term);
    always_comb begin
        w_x = r_a[w_idx[7:4]];
        case (r_op)
            m3a_pkg::OP_MUL,
            m3a_pkg::OP_ADD,
            m3a_pkg::OP_SUB:    w_y = r_b[w_idx[3:0]];
            m3a_pkg::OP_SCALE:  w_y = r_val;
            m3a_pkg::OP_INV:    w_y = r_a[w_idx[3:0]];
            default:            w_y = 32'sd0;
        endcase
    end

    // shared unit control
    always_comb begin
        w_ctl.mul_en = 1'b0;
        w_ctl.acc_op = m3a_pkg::ACC_NOP;
        w_div_start  = 1'b0;
        case (r_state)
            ST_MUL: begin
                if (w_direct) begin
                    w_ctl.acc_op = (r_op == m3a_pkg::OP_SUB) ? m3a_pkg::ACC_DIFF
                                                              : m3a_pkg::ACC_SUM;
                end else begin
                    w_ctl.mul_en = 1'b1;
                end
            end
            ST_ACC: begin
                if (r_term == 2'd0) begin
                    w_ctl.acc_op = m3a_pkg::ACC_SET;
                end else if (r_op == m3a_pkg::OP_INV) begin
                    w_ctl.acc_op = m3a_pkg::ACC_SUB;
                end else begin
                    w_ctl.acc_op = m3a_pkg::ACC_ADD;
                end
            end
            ST_FIN: begin
                w_div_start = (r_op == m3a_pkg::OP_INV);
            end
            default: begin
                w_ctl.mul_en = 1'b0;
            end
        endcase
    end

    m3a_mac u_mac (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_x       (w_x),
        .i_y       (w_y),
        .o_acc     (w_acc),
        .o_sat_val (w_sat_val),
        .o_sat     (w_sat)
    );

    m3a_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_cof   (w_acc),
        .i_det   (r_val),
        .o_done  (w_div_done),
        .o_q     (w_div_q),
        .o_sat   (w_div_sat)
    );

    // sequencer and matrix storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int i = 0; i < 9; i++) begin
                r_a[i] <= 32'sd0;
                r_b[i] <= 32'sd0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_req_acc) begin
                        case (i_req_ch.req_type)
                            m3a_pkg::REQ_LOAD_A: begin
                                if (i_req_ch.elem_index <= m3a_pkg::LAST_ELEM) begin
                                    r_a[i_req_ch.elem_index] <= i_req_ch.operand_value;
                                end
                            end
                            m3a_pkg::REQ_LOAD_B: begin
                                if (i_req_ch.elem_index <= m3a_pkg::LAST_ELEM) begin
                                    r_b[i_req_ch.elem_index] <= i_req_ch.operand_value;
                                end
                            end
                            m3a_pkg::REQ_EXEC: begin
                                if (i_req_ch.op_code <= m3a_pkg::OP_INV) begin
                                    r_op   <= i_req_ch.op_code;
                                    r_val  <= i_req_ch.operand_value;
                                    r_elem <= 4'd0;
                                    r_term <= 2'd0;
                                    if (i_req_ch.op_code == m3a_pkg::OP_INV &&
                                        i_req_ch.operand_value == 32'sd0) begin
                                        r_dz <= 1'b1;
                                        for (int i = 0; i < 9; i++) begin
                                            r_res[i] <= 32'sd0;
                                            r_sat[i] <= 1'b0;
                                        end
                                        r_state <= ST_WB;
                                    end else begin
                                        r_dz    <= 1'b0;
                                        r_state <= ST_MUL;
                                    end
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    r_state <= w_direct ? ST_FIN : ST_ACC;
                end
                ST_ACC: begin
                    if (r_term == w_last_term) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_term  <= r_term + 2'd1;
                        r_state <= ST_MUL;
                    end
                end
                ST_FIN: begin
                    if (r_op == m3a_pkg::OP_INV) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_res[r_elem] <= w_sat_val;
                        r_sat[r_elem] <= w_sat;
                        r_term        <= 2'd0;
                        r_elem        <= r_elem + 4'd1;
                        r_state       <= (r_elem == m3a_pkg::LAST_ELEM) ? ST_WB : ST_MUL;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_res[r_elem] <= w_div_q;
                        r_sat[r_elem] <= w_div_sat;
                        r_term        <= 2'd0;
                        r_elem        <= r_elem + 4'd1;
                        r_state       <= (r_elem == m3a_pkg::LAST_ELEM) ? ST_WB : ST_MUL;
                    end
                end
                ST_WB: begin
                    for (int i = 0; i < 9; i++) begin
                        r_a[i] <= r_res[i];
                    end
                    r_oidx  <= 4'd0;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_oidx  <= r_oidx + 4'd1;
                        r_state <= (r_oidx == m3a_pkg::LAST_ELEM) ? ST_IDLE : ST_OUT;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_oindex <= r_oidx;
            r_ovalue <= r_res[r_oidx];
            r_olast  <= (r_oidx == m3a_pkg::LAST_ELEM);
            r_osat   <= r_sat[r_oidx];
            r_odz    <= r_dz;
        end
    end

    assign o_res_ch.valid     = r_ovalid;
    assign o_res_ch.out_index = r_oindex;
    assign o_res_ch.out_value = r_ovalue;
    assign o_res_ch.last_elem = r_olast;
    assign o_res_ch.saturated = r_osat;
    assign o_res_ch.div_zero  = r_odz;

endmodule

>>> sim/matrix3x3_alu_chk.sv
// Checker: watches both channels, predicts result words, compares
module matrix3x3_alu_chk (
    input  logic      i_clk,
    input  logic      i_rst_n,
    m3a_req_if        i_req,
    m3a_res_if        i_res,
    output int        o_fail_cnt,
    output int        o_pending
);

    typedef struct {
        logic [3:0]         index;
        logic signed [31:0] value;
        logic               last;
        logic               sat;
        logic               dz;
    } t_elem_word;

    logic signed [31:0] mat_a [9];
    logic signed [31:0] mat_b [9];
    t_elem_word         elem_q [$];
    int                 fail_cnt;

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = elem_q.size();

    // Q16.16 product, round to nearest with ties upward
    function automatic logic signed [63:0] rnd_mul(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
        logic signed [63:0] p;
        p = 64'(x) * 64'(y) + 64'sh8000;
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v,
                                                  inout logic sat);
        if (v > 64'sh7FFFFFFF) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sh80000000) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // (cof << 16) / det, truncated toward zero, then clipped
    function automatic logic signed [31:0] cof_div(input logic signed [63:0] cof,
                                                   input logic signed [31:0] det,
                                                   inout logic sat);
        logic        neg;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        neg = (cof < 0) != (det < 0);
        num = (cof < 0) ? 64'(-cof) : 64'(cof);
        den = (det < 0) ? 64'(-64'(det)) : 64'(det);
        q   = (num << 16) / den;
        if (neg) begin
            if (q > 64'h80000000) begin
                sat = 1'b1;
                return 32'sh80000000;
            end
            return 32'(-$signed(q));
        end
        if (q > 64'h7FFFFFFF) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        return q[31:0];
    endfunction

    task automatic predict_exec(input logic [2:0] op, input logic signed [31:0] opnd);
        logic signed [63:0] acc;
        logic signed [63:0] cof [9];
        logic signed [31:0] res [9];
        logic               sat [9];
        int                 r;
        int                 c;
        for (int i = 0; i < 9; i++) begin
            res[i] = '0;
            sat[i] = 1'b0;
        end
        case (op)
            m3a_pkg::OP_MUL: begin
                for (r = 0; r < 3; r++) begin
                    for (c = 0; c < 3; c++) begin
                        acc = rnd_mul(mat_a[r*3], mat_b[c]) + rnd_mul(mat_a[r*3+1], mat_b[3+c])
                            + rnd_mul(mat_a[r*3+2], mat_b[6+c]);
                        res[r*3+c] = clip32(acc, sat[r*3+c]);
                    end
                end
            end
            m3a_pkg::OP_ADD, m3a_pkg::OP_SUB: begin
                for (int i = 0; i < 9; i++) begin
                    acc = (op == m3a_pkg::OP_ADD) ? 64'(mat_a[i]) + 64'(mat_b[i])
                                                  : 64'(mat_a[i]) - 64'(mat_b[i]);
                    res[i] = clip32(acc, sat[i]);
                end
            end
            m3a_pkg::OP_SCALE: begin
                for (int i = 0; i < 9; i++)
                    res[i] = clip32(rnd_mul(mat_a[i], opnd), sat[i]);
            end
            m3a_pkg::OP_TRANSP: begin
                for (r = 0; r < 3; r++)
                    for (c = 0; c < 3; c++)
                        res[r*3+c] = mat_a[c*3+r];
            end
            default: begin
                if (opnd != 0) begin
                    cof[0] = rnd_mul(mat_a[4], mat_a[8]) - rnd_mul(mat_a[7], mat_a[5]);
                    cof[3] = rnd_mul(mat_a[5], mat_a[6]) - rnd_mul(mat_a[3], mat_a[8]);
                    cof[6] = rnd_mul(mat_a[3], mat_a[7]) - rnd_mul(mat_a[6], mat_a[4]);
                    cof[1] = rnd_mul(mat_a[2], mat_a[7]) - rnd_mul(mat_a[1], mat_a[8]);
                    cof[4] = rnd_mul(mat_a[0], mat_a[8]) - rnd_mul(mat_a[2], mat_a[6]);
                    cof[7] = rnd_mul(mat_a[6], mat_a[1]) - rnd_mul(mat_a[0], mat_a[7]);
                    cof[2] = rnd_mul(mat_a[1], mat_a[5]) - rnd_mul(mat_a[2], mat_a[4]);
                    cof[5] = rnd_mul(mat_a[3], mat_a[2]) - rnd_mul(mat_a[0], mat_a[5]);
                    cof[8] = rnd_mul(mat_a[0], mat_a[4]) - rnd_mul(mat_a[3], mat_a[1]);
                    for (int i = 0; i < 9; i++)
                        res[i] = cof_div(cof[i], opnd, sat[i]);
                end
            end
        endcase
        // queue the nine words and write the result back into A
        for (int i = 0; i < 9; i++) begin
            elem_q.push_back('{index: 4'(i), value: res[i], last: (i == 8), sat: sat[i],
                               dz: (op == m3a_pkg::OP_INV && opnd == 0)});
            mat_a[i] = res[i];
        end
    endtask

    // request side: track matrix state and predict
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
        end else if (i_req.valid && i_req.ready) begin
            case (i_req.req_type)
                m3a_pkg::REQ_LOAD_A: if (i_req.elem_index <= m3a_pkg::LAST_ELEM)
                    mat_a[i_req.elem_index] = i_req.operand_value;
                m3a_pkg::REQ_LOAD_B: if (i_req.elem_index <= m3a_pkg::LAST_ELEM)
                    mat_b[i_req.elem_index] = i_req.operand_value;
                m3a_pkg::REQ_EXEC: if (i_req.op_code <= m3a_pkg::OP_INV)
                    predict_exec(i_req.op_code, i_req.operand_value);
                default: ;
            endcase
        end
    end

    // result side: compare each word with the oldest expectation
    initial fail_cnt = 0;
    always @(posedge i_clk) begin
        t_elem_word w;
        if (i_rst_n && i_res.valid && i_res.ready) begin
            if (elem_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result word: idx %0d val %0h", i_res.out_index,
                             i_res.out_value);
            end else begin
                w = elem_q.pop_front();
                if (w.index !== i_res.out_index || w.value !== i_res.out_value ||
                    w.last !== i_res.last_elem || w.sat !== i_res.saturated ||
                    w.dz !== i_res.div_zero) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("word mismatch: exp idx %0d val %0h l%b s%b z%b, got idx %0d val %0h l%b s%b z%b",
                                 w.index, w.value, w.last, w.sat, w.dz, i_res.out_index,
                                 i_res.out_value, i_res.last_elem, i_res.saturated,
                                 i_res.div_zero);
                end
            end
        end
    end

endmodule

>>> sim/matrix3x3_alu_tb.sv
// Top: clock, reset, request stimulus, result back-pressure and verdict
module matrix3x3_alu_tb;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending;
    int   cyc = 0;
    int   burst_left;
    int   gap_left;

    m3a_req_if req_ch ();
    m3a_res_if res_ch ();

    matrix3x3_alu dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req_ch (req_ch),
        .o_res_ch (res_ch)
    );

    matrix3x3_alu_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .i_res      (res_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stall pattern: phases of free flow and of random stalling
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_ch.ready <= 1'b0;
        else if (cyc % 1000 < 300)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > 600000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            3:       return 32'($signed($urandom_range(0, 512)) - 256);
            default: return $urandom;
        endcase
    endfunction

    // send one word, with burst/gap pacing on the sender side
    task automatic send_word(input logic [1:0] rt, input logic [3:0] idx,
                             input logic [31:0] v, input logic [2:0] op);
        if (burst_left == 0) begin
            gap_left = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 8);
            if (gap_left > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap_left) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= rt;
        req_ch.elem_index    <= idx;
        req_ch.operand_value <= v;
        req_ch.op_code       <= op;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic load_matrix(input logic [1:0] rt, input int mode);
        for (int i = 0; i < 9; i++)
            send_word(rt, 4'(i), (mode == 0) ? rand_val()
                                 : 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16)),
                      3'($urandom));
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [2:0] op;
        burst_left = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = m3a_pkg::REQ_LOAD_A;
        req_ch.elem_index = '0;
        req_ch.operand_value = '0;
        req_ch.op_code = m3a_pkg::OP_MUL;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every op, zero determinant, ignored items
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'd0, m3a_pkg::OP_INV);
        send_word(m3a_pkg::REQ_LOAD_A, 4'd0, 32'h7FFFFFFF, m3a_pkg::OP_MUL);
        send_word(m3a_pkg::REQ_LOAD_A, 4'd4, 32'h80000000, m3a_pkg::OP_MUL);
        send_word(m3a_pkg::REQ_LOAD_A, 4'd8, 32'h00010000, m3a_pkg::OP_MUL);
        send_word(m3a_pkg::REQ_LOAD_B, 4'd0, 32'h7FFFFFFF, m3a_pkg::OP_MUL);
        send_word(m3a_pkg::REQ_LOAD_B, 4'd4, 32'h7FFFFFFF, m3a_pkg::OP_MUL);
        send_word(m3a_pkg::REQ_LOAD_A, 4'd15, 32'hFFFFFFFF, 3'd7);
        send_word(m3a_pkg::REQ_LOAD_B, 4'd9, 32'h12345678, 3'd7);
        send_word(2'd3, 4'd3, 32'h1, m3a_pkg::OP_MUL);
        send_word(m3a_pkg::REQ_EXEC, 4'd15, 32'h1, 3'd6);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'h0, 3'd7);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'h0, m3a_pkg::OP_ADD);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'h0, m3a_pkg::OP_SUB);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'h0, m3a_pkg::OP_SUB);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'h80000000, m3a_pkg::OP_SCALE);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'h7FFFFFFF, m3a_pkg::OP_SCALE);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'h0, m3a_pkg::OP_TRANSP);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'h0, m3a_pkg::OP_MUL);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'h00000001, m3a_pkg::OP_INV);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'hFFFFFFFF, m3a_pkg::OP_INV);
        send_word(m3a_pkg::REQ_EXEC, 4'd0, 32'h0, m3a_pkg::OP_INV);
        // sender holds off until every word is back
        wait_drain();

        // random: matrix loads with random content, then an execute
        for (int n = 0; n < 17; n++) begin
            load_matrix(m3a_pkg::REQ_LOAD_A, n % 2);
            if ($urandom_range(0, 1)) load_matrix(m3a_pkg::REQ_LOAD_B, n % 3);
            op = 3'($urandom_range(0, 5));
            send_word(m3a_pkg::REQ_EXEC, 4'($urandom),
                      (op == m3a_pkg::OP_INV && $urandom_range(0, 4) == 0)
                      ? 32'd0 : rand_val(), op);
            if ($urandom_range(0, 5) == 0)
                send_word(3'($urandom_range(0, 3)) == 3 ? 2'd3 : m3a_pkg::REQ_EXEC,
                          4'($urandom), $urandom, 3'($urandom_range(6, 7)));
            if (n == 8) wait_drain();
        end

        wait_drain();
        repeat (600) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
